### sv/sech_pkg.sv
// shared types and constants for the coalesced hash insert block
`timescale 1ns / 1ps
package sech_pkg;

    localparam int DEF_MAX_SLOTS  = 1024;
    localparam int DEF_INDEX_BITS = 16;

    localparam int ROW_W      = 17;
    localparam int COL_W      = 17;
    localparam int VAL_W      = 64;
    localparam int SLOT_W     = 10;
    localparam int SIZE_W     = 11;
    localparam int COLS_W     = 17;
    localparam int KEY_W      = 64;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;
    localparam logic [COLS_W-1:0] COLS_RESET = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS    = 8'd1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_KEY,
        S_DIV,
        S_HOME_RD,
        S_HOME_CK,
        S_PROBE_RD,
        S_PROBE_CK,
        S_WALK_RD,
        S_WALK_CK,
        S_LINK_WR,
        S_WRITE,
        S_FULL
    } t_state;

endpackage

### sv/sech_ram.sv
// generic single-port ram with registered read
`timescale 1ns / 1ps
module sech_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

### sv/sech_mod.sv
// bit-serial remainder of the 64-bit key by the table size
`timescale 1ns / 1ps
module sech_mod
    import sech_pkg::*;
#(
    parameter int REM_W = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_dividend,
    input  logic [REM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [REM_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(KEY_W);

    logic             r_run;
    logic [CNT_W-1:0] r_cnt;
    logic [KEY_W-1:0] r_num;
    logic [REM_W-1:0] r_div;
    logic [REM_W-1:0] r_rem;
    logic             r_done;
    logic [REM_W:0]   w_sh;
    logic [REM_W-1:0] w_rem;

    // one restoring step: shift in a dividend bit, subtract if it fits
    always_comb begin
        w_sh = {r_rem, r_num[KEY_W-1]};
        if (w_sh >= {1'b0, r_div}) begin
            w_rem = REM_W'(w_sh - {1'b0, r_div});
        end else begin
            w_rem = w_sh[REM_W-1:0];
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(KEY_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_run) begin
            r_num <= {r_num[KEY_W-2:0], 1'b0};
            r_rem <= w_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

### sv/sparse_entry_coalesced_hash_insert_top.sv
// top level: coalesced hash insert of one sparse matrix entry
// an entry runs from accept through the key product, the 64-step serial remainder, a read and
// check of the home slot and the write; an occupied home adds probe reads, link reads and a
// link write; one entry at a time; busy drops in the strobe cycle, so the next entry can be
// accepted from that cycle on; results cannot be stalled
// reset: synchronous, active low; then a clearing pass over all MAX_SLOTS slots with busy high
`timescale 1ns / 1ps
module sparse_entry_coalesced_hash_insert_top
    import sech_pkg::*;
#(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int INDEX_BITS = DEF_INDEX_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ROW_W-1:0]      i_row_number,
    input  logic [COL_W-1:0]      i_column_number,
    input  logic [VAL_W-1:0]      i_entry_bits,
    output logic                  o_valid,
    output logic [SLOT_W-1:0]     o_slot_used,
    output logic                  o_collided,
    output logic                  o_table_full,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int ADDR_W = $clog2(MAX_SLOTS);
    localparam int EW     = ADDR_W + 1;
    localparam int CW     = (EW > SIZE_W) ? EW : SIZE_W;
    localparam int DW     = VAL_W + 2 * INDEX_BITS;
    localparam int LW     = ADDR_W + 1;

    t_state r_state, n_state;

    logic [SIZE_W-1:0]     r_size;
    logic [COLS_W-1:0]     r_cols;
    logic [ROW_W-1:0]      r_row;
    logic [COL_W-1:0]      r_col;
    logic [VAL_W-1:0]      r_val;
    logic signed [35:0]    r_prod;
    logic [ADDR_W-1:0]     r_home, n_home;
    logic [ADDR_W-1:0]     r_probe, n_probe;
    logic [ADDR_W-1:0]     r_cur, n_cur;
    logic [ADDR_W-1:0]     r_clr;
    logic [EW-1:0]         r_n, n_n;
    logic [EW-1:0]         r_steps, n_steps;
    logic [ADDR_W-1:0]     r_target, n_target;
    logic                  r_coll, n_coll;
    logic                  r_o_valid, n_o_valid;
    logic [SLOT_W-1:0]     r_o_slot, n_o_slot;
    logic                  r_o_coll, n_o_coll;
    logic                  r_o_full, n_o_full;

    logic [EW-1:0]         w_eff;
    logic [CW-1:0]         w_size_x;
    logic signed [17:0]    w_r;
    logic signed [17:0]    w_c;
    logic signed [36:0]    w_key37;
    logic [KEY_W-1:0]      w_key;
    logic [31:0]           w_r32;
    logic [31:0]           w_c32;
    logic [EW-1:0]         w_p1;
    logic [ADDR_W-1:0]     w_pnext;
    logic [SLOT_W+ADDR_W-1:0] w_slot_x;

    logic                  d_we;
    logic [ADDR_W-1:0]     d_addr;
    logic [DW-1:0]         d_wdata;
    logic [DW-1:0]         d_rdata;
    logic                  l_we;
    logic [ADDR_W-1:0]     l_addr;
    logic [LW-1:0]         l_wdata;
    logic [LW-1:0]         l_rdata;
    logic                  w_empty;
    logic                  div_start;
    logic                  div_done;
    logic [EW-1:0]         div_rem;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= SIZE_RESET;
            r_cols <= COLS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TABLE_SIZE: r_size <= i_cfg_data[SIZE_W-1:0];
                CFG_COLUMNS:    r_cols <= i_cfg_data[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // effective table size, clamped to one and to the slot count
    always_comb begin
        w_size_x = CW'(r_size);
        if (w_size_x == '0) begin
            w_eff = EW'(1);
        end else if (w_size_x > CW'(MAX_SLOTS)) begin
            w_eff = EW'(MAX_SLOTS);
        end else begin
            w_eff = EW'(w_size_x);
        end
    end

    // zero-based row and column, wrapping below zero, and the linear key
    assign w_r     = $signed({1'b0, r_row}) - 18'sd1;
    assign w_c     = $signed({1'b0, r_col}) - 18'sd1;
    assign w_key37 = {r_prod[35], r_prod} + {{19{w_c[17]}}, w_c};
    assign w_key   = {{(KEY_W - 37){w_key37[36]}}, w_key37};
    assign w_r32   = {{14{w_r[17]}}, w_r};
    assign w_c32   = {{14{w_c[17]}}, w_c};

    // next probe slot with wrap at table size
    assign w_p1    = EW'(r_probe) + 1'b1;
    assign w_pnext = (w_p1 == w_eff) ? '0 : w_p1[ADDR_W-1:0];

    assign w_empty = (d_rdata[VAL_W-2:0] == '0);

    sech_mod #(
        .REM_W (EW)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (w_key),
        .i_divisor  (w_eff),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    sech_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_addr  (d_addr),
        .i_wdata (d_wdata),
        .o_rdata (d_rdata)
    );

    sech_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_addr  (l_addr),
        .i_wdata (l_wdata),
        .o_rdata (l_rdata)
    );

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_row <= i_row_number;
            r_col <= i_column_number;
            r_val <= i_entry_bits;
        end
        if (r_state == S_MUL) begin
            r_prod <= w_r * $signed({1'b0, r_cols});
        end
        r_home   <= n_home;
        r_probe  <= n_probe;
        r_cur    <= n_cur;
        r_n      <= n_n;
        r_steps  <= n_steps;
        r_target <= n_target;
        r_coll   <= n_coll;
        r_o_slot <= n_o_slot;
        r_o_coll <= n_o_coll;
        r_o_full <= n_o_full;
    end

    assign w_slot_x = {{SLOT_W{1'b0}}, r_target};

    // next state, memory access and result
    always_comb begin
        n_state   = r_state;
        n_home    = r_home;
        n_probe   = r_probe;
        n_cur     = r_cur;
        n_n       = r_n;
        n_steps   = r_steps;
        n_target  = r_target;
        n_coll    = r_coll;
        n_o_valid = 1'b0;
        n_o_slot  = r_o_slot;
        n_o_coll  = r_o_coll;
        n_o_full  = r_o_full;
        div_start = 1'b0;
        d_we      = 1'b0;
        d_addr    = r_home;
        d_wdata   = {w_c32[INDEX_BITS-1:0], w_r32[INDEX_BITS-1:0], r_val};
        l_we      = 1'b0;
        l_addr    = r_cur;
        l_wdata   = {1'b1, r_probe};
        unique case (r_state)
            S_CLEAR: begin
                d_we    = 1'b1;
                d_addr  = r_clr;
                d_wdata = '0;
                l_we    = 1'b1;
                l_addr  = r_clr;
                l_wdata = '0;
                if (r_clr == ADDR_W'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_state = S_KEY;
            end
            S_KEY: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_home  = div_rem[ADDR_W-1:0];
                    n_state = S_HOME_RD;
                end
            end
            S_HOME_RD: begin
                d_addr  = r_home;
                n_state = S_HOME_CK;
            end
            S_HOME_CK: begin
                if (w_empty) begin
                    n_target = r_home;
                    n_coll   = 1'b0;
                    n_state  = S_WRITE;
                end else begin
                    n_probe = r_home;
                    n_n     = EW'(1);
                    n_state = S_PROBE_RD;
                end
            end
            S_PROBE_RD: begin
                if (r_n >= w_eff) begin
                    n_state = S_FULL;
                end else begin
                    d_addr  = w_pnext;
                    n_probe = w_pnext;
                    n_state = S_PROBE_CK;
                end
            end
            S_PROBE_CK: begin
                if (w_empty) begin
                    n_cur   = r_home;
                    n_steps = '0;
                    n_state = S_WALK_RD;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_state = S_PROBE_RD;
                end
            end
            S_WALK_RD: begin
                l_addr  = r_cur;
                n_state = S_WALK_CK;
            end
            S_WALK_CK: begin
                if (l_rdata[LW-1] && (r_steps < EW'(MAX_SLOTS))) begin
                    n_cur   = l_rdata[ADDR_W-1:0];
                    n_steps = r_steps + 1'b1;
                    n_state = S_WALK_RD;
                end else begin
                    n_state = S_LINK_WR;
                end
            end
            S_LINK_WR: begin
                l_we     = 1'b1;
                l_addr   = r_cur;
                l_wdata  = {1'b1, r_probe};
                n_target = r_probe;
                n_coll   = 1'b1;
                n_state  = S_WRITE;
            end
            S_WRITE: begin
                d_we      = 1'b1;
                d_addr    = r_target;
                n_o_valid = 1'b1;
                n_o_slot  = w_slot_x[SLOT_W-1:0];
                n_o_coll  = r_coll;
                n_o_full  = 1'b0;
                n_state   = S_IDLE;
            end
            S_FULL: begin
                n_o_valid = 1'b1;
                n_o_slot  = '0;
                n_o_coll  = 1'b0;
                n_o_full  = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy         = (r_state != S_IDLE);
    assign o_valid      = r_o_valid;
    assign o_slot_used  = r_o_slot;
    assign o_collided   = r_o_coll;
    assign o_table_full = r_o_full;

    // a result strobe lasts one cycle and is never followed by another at once
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // a full table reports no slot and no collision
    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_table_full) |-> (o_slot_used == '0 && !o_collided))
        else $error("full result carries slot or collision");

    // an accepted transaction makes the block busy
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // the clearing pass keeps new transactions out
    a_clear_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> busy)
        else $error("idle during clearing pass");

endmodule

### test/tb_sparse_entry_coalesced_hash_insert_top.sv
// testbench for the coalesced hash insert block: directed table, random phases, self-checking
`timescale 1ns / 1ps
module tb_sparse_entry_coalesced_hash_insert_top
    import sech_pkg::*;
();

    localparam int SLOTS      = DEF_MAX_SLOTS;
    localparam int IDLE_LIMIT = 50000;
    localparam logic [31:0] NO_LINK = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              coll;
        logic              full;
    } t_insert_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_DATA_W-1:0]  data;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [VAL_W-1:0]       bits;
        bit                     typed;
        t_insert_res            res;
    } t_stim_row;

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  start = 0;
    logic                  busy;
    logic [ROW_W-1:0]      i_row_number = '0;
    logic [COL_W-1:0]      i_column_number = '0;
    logic [VAL_W-1:0]      i_entry_bits = '0;
    logic                  o_valid;
    logic [SLOT_W-1:0]     o_slot_used;
    logic                  o_collided;
    logic                  o_table_full;
    logic                  i_cfg_valid = 0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow copy of the table state and registers
    logic [VAL_W-1:0]  shadow_value [SLOTS];
    logic [31:0]       shadow_link [SLOTS];
    logic [SIZE_W-1:0] shadow_size;
    logic [COLS_W-1:0] shadow_cols;

    t_insert_res pending_inserts[$];
    int errors = 0;
    int n_results = 0;
    int n_coll = 0;
    int n_full = 0;
    int idle_cycles = 0;

    sparse_entry_coalesced_hash_insert_top uut (.*);

    always #5 i_clk = ~i_clk;

    // expected slot, chaining and full flag for one insert; updates the shadow table
    function automatic t_insert_res predict_insert(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col,
                                                   input logic [VAL_W-1:0] bits);
        longint unsigned sz, r, c, key, home, probe, cur;
        int n, steps;
        bit found;
        t_insert_res res;
        sz = (shadow_size == 0) ? 1 : (shadow_size > SLOTS) ? SLOTS : shadow_size;
        r = longint'(row) - 1;
        c = longint'(col) - 1;
        key = r * longint'(shadow_cols) + c;
        home = key % sz;
        probe = home;
        res = '{slot: home[SLOT_W-1:0], coll: 1'b0, full: 1'b0};
        if (shadow_value[home][62:0] != 0) begin
            found = 0;
            for (n = 1; n < sz && !found; n++) begin
                probe = (probe + 1) % sz;
                if (shadow_value[probe][62:0] == 0) found = 1;
            end
            if (!found) return '{slot: '0, coll: 1'b0, full: 1'b1};
            // walk the chain from home to its end, broken links stop it
            cur = home;
            steps = 0;
            while (steps < SLOTS && shadow_link[cur] < SLOTS) begin
                cur = 64'(shadow_link[cur]);
                steps++;
            end
            shadow_link[cur] = 32'(probe);
            res = '{slot: probe[SLOT_W-1:0], coll: 1'b1, full: 1'b0};
        end
        shadow_value[probe] = bits;
        return res;
    endfunction

    // one insert transaction; start stays high for the caller to lower
    task automatic send_entry(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                              input logic [VAL_W-1:0] bits, input bit typed,
                              input t_insert_res typed_res);
        t_insert_res res;
        start <= 1;
        i_cfg_valid <= 0;
        i_row_number <= row;
        i_column_number <= col;
        i_entry_bits <= bits;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        res = predict_insert(row, col, bits);
        pending_inserts.push_back(typed ? typed_res : res);
    endtask

    task automatic drain;
        start <= 0;
        while (pending_inserts.size() != 0 || busy) @(posedge i_clk);
    endtask

    // register write; valid stays high for the caller to lower
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_TABLE_SIZE) shadow_size = data[SIZE_W-1:0];
        else if (idx == CFG_COLUMNS) shadow_cols = data[COLS_W-1:0];
    endtask

    task automatic idle_gap(input bit quiet);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            start <= 0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    // check each result strobe against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_inserts.size() == 0) begin
                $display("%0t: unexpected result slot=%0d coll=%0b full=%0b",
                         $time, o_slot_used, o_collided, o_table_full);
                errors++;
            end else begin
                t_insert_res e;
                e = pending_inserts.pop_front();
                if (o_slot_used !== e.slot || o_collided !== e.coll
                        || o_table_full !== e.full) begin
                    $display("%0t: mismatch exp slot=%0d coll=%0b full=%0b got %0d %0b %0b",
                             $time, e.slot, e.coll, e.full,
                             o_slot_used, o_collided, o_table_full);
                    errors++;
                end
            end
            n_results++;
            n_coll += o_collided;
            n_full += o_table_full;
        end
    end

    // watchdog on cycles with no transaction of any kind
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Regression FAIL");
            $finish;
        end
    end

    t_stim_row directed[] = '{
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 1, 1, 64'd1, 1, '{10'd0, 1'b0, 1'b0}},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 1, 1, '1, 1, '{10'd1, 1'b1, 1'b0}},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 0, 0, 64'h8000_0000_0000_0001, 1,
          '{10'd1023, 1'b0, 1'b0}},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 65536, 65536, 64'h1234_5678_9ABC_DEF0, 0, '0},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 17'h1FFFF, 17'h1FFFF, 64'h8000_0000_0000_0000, 0, '0},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 2, 3, 64'd0, 0, '0},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 2, 3, 64'd5, 0, '0},
        '{ROW_CFG, CFG_TABLE_SIZE, 32'd1, 0, 0, 0, 0, '0},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 1, 1, 64'd7, 1, '{10'd0, 1'b0, 1'b1}},
        '{ROW_CFG, CFG_TABLE_SIZE, 32'd0, 0, 0, 0, 0, '0},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 9, 4, 64'd0, 1, '{10'd0, 1'b0, 1'b1}},
        '{ROW_CFG, CFG_TABLE_SIZE, 32'hFFFF_F7FF, 0, 0, 0, 0, '0},
        '{ROW_CFG, CFG_COLUMNS, 32'd0, 0, 0, 0, 0, '0},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 5, 9, 64'h7FF0_0000_0000_0000, 0, '0},
        '{ROW_CFG, CFG_COLUMNS, 32'd1, 0, 0, 0, 0, '0},
        '{ROW_ITEM, CFG_TABLE_SIZE, 0, 300, 1, 64'h3FF0_0000_0000_0000, 0, '0},
        '{ROW_CFG, CFG_TABLE_SIZE, 32'd1024, 0, 0, 0, 0, '0},
        '{ROW_CFG, CFG_COLUMNS, 32'd65536, 0, 0, 0, 0, '0}
    };

    int phase_sizes[] = '{1024, 16, 4, 1, 64, 2047, 200, 2, 1000};

    initial begin
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] bits;
        logic [CFG_DATA_W-1:0] cols_data;
        bit quiet;
        foreach (shadow_value[k]) begin
            shadow_value[k] = '0;
            shadow_link[k] = NO_LINK;
        end
        shadow_size = SIZE_RESET;
        shadow_cols = COLS_RESET;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1;

        // directed table
        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG) begin
                drain();
                write_reg(directed[i].idx, directed[i].data);
            end else begin
                send_entry(directed[i].row, directed[i].col, directed[i].bits,
                           directed[i].typed, directed[i].res);
                idle_gap(0);
            end
        end

        // random phases over several table sizes and column counts
        foreach (phase_sizes[p]) begin
            quiet = (p == phase_sizes.size() - 1);
            drain();
            case ($urandom_range(0, 4))
                0: cols_data = 1;
                1: cols_data = 65536;
                2: cols_data = 0;
                3: cols_data = $urandom_range(1, 300);
                default: cols_data = $urandom_range(1, 65536);
            endcase
            write_reg(CFG_TABLE_SIZE, {$urandom} << SIZE_W | phase_sizes[p]);
            write_reg(CFG_COLUMNS, {$urandom} << COLS_W | cols_data);
            repeat (60) begin
                case ($urandom_range(0, 9))
                    0: begin row = ROW_W'($urandom); col = COL_W'($urandom); end
                    1, 2, 3: begin
                        row = ROW_W'($urandom_range(1, 65536));
                        col = COL_W'($urandom_range(1, 65536));
                    end
                    default: begin
                        row = ROW_W'($urandom_range(1, 64));
                        col = COL_W'($urandom_range(1, 64));
                    end
                endcase
                case ($urandom_range(0, 9))
                    0: bits = 64'd0;
                    1: bits = 64'h8000_0000_0000_0000;
                    default: bits = {$urandom, $urandom};
                endcase
                send_entry(row, col, bits, 0, '0);
                idle_gap(quiet);
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("covered %0d inserts over %0d table sizes: %0d chained, %0d table full",
                 n_results, phase_sizes.size(), n_coll, n_full);
        if (errors == 0 && pending_inserts.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, pending_inserts.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
